// ===== rtl/core/mabsr_pkg.sv =====
// Package with shared types and constants for the multi-axis step interpolator.
`default_nettype none
package mabsr_pkg;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int AXES_DEF = 3;
    localparam int FRAC_BITS_DEF = 8;
    localparam logic [15:0] INIT_INTERVAL_RST = 16'd6200;
    localparam logic [15:0] MIN_INTERVAL_RST = 16'd1000;
    localparam logic [2:0] AXIS_ENABLE_RST = 3'd3;

    typedef enum logic [2:0] {
        CMD_ENQUEUE = 3'd0,
        CMD_RUN     = 3'd1,
        CMD_ALARM   = 3'd2,
        CMD_STOP    = 3'd3,
        CMD_ZERO    = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        REG_INIT_INTERVAL = 2'd0,
        REG_MIN_INTERVAL  = 2'd1,
        REG_AXIS_ENABLE   = 2'd2
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_RD_WAIT,
        ST_START,
        ST_START2,
        ST_ALARM,
        ST_DIV_SETUP,
        ST_DIV,
        ST_RAMP,
        ST_OUT
    } state_t;
endpackage
`default_nettype wire

// ===== rtl/core/mabsr_ram.sv =====
// Generic single-port-write, registered-read RAM.
`default_nettype none
module mabsr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/core/multi_axis_bresenham_stepper_ramp_unit.sv =====
// Top level of the three-axis Bresenham step interpolator with speed ramp.
//
// Usage: commands arrive on the s_axis channel (tuser = cmd, tdata = targets),
// one result per command leaves on m_axis. Configuration registers are to be written
// on the cfg channel (index 0 initial interval, 1 minimum interval, 2 axis
// enable) only while the block is idle; the block itself does not enforce this.
// Sequence: enqueue, stop, zero, a run that starts no move and an alarm with no
// move to continue go from the read state straight to the output register; a run
// that starts a move reads the queue, then starts it; an alarm event that
// continues a move steps each axis in turn, then passes the ramp divider, a
// bit-serial divider that retires one quotient bit a cycle, and the ramp state.
// One command is worked on at a time; s_axis_tready is high only when no
// command is in flight and the output register is empty.
// Reset clears the queue, positions, move state and loads default registers.
// When the receiver stalls, the result is held in the output register and
// no new command is taken until it is delivered.
`default_nettype none
module multi_axis_bresenham_stepper_ramp_unit
    import mabsr_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int AXES = AXES_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // tdata: target_x [31:0], target_y [63:32], target_z [95:64]
    input  wire logic [95:0]  s_axis_tdata,
    // tuser: cmd [2:0]
    input  wire logic [2:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // tdata: step_mask [2:0], dir_mask [5:3], next_delay_us [20:6], moving [21],
    // idle [22], accepted [23], queued [28:24], pos_x [60:29], pos_y [92:61],
    // pos_z [124:93], zero [127:125]
    output logic [127:0]      m_axis_tdata,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [15:0]  cfg_data
);
    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam int IW = 16 + FRAC_BITS;
    localparam int DW = IW + 1;
    localparam int CW = $clog2(DW + 1);
    localparam logic [IW-1:0] IV_MAX = {16'hFFFF, {FRAC_BITS{1'b0}}};

    state_t state_reg, state_next;

    logic [15:0] init_iv_reg, min_iv_reg;
    logic [2:0]  en_reg;

    logic [QW-1:0] head_reg, tail_reg;
    logic [FW-1:0] fill_reg;
    logic [31:0] pos_reg [3];
    logic [31:0] dist_reg [3];
    logic [31:0] err_reg [3];
    logic [31:0] done_reg [3];
    logic [2:0]  neg_reg;
    logic [31:0] longest_reg;
    logic [1:0]  lead_reg;
    logic        active_reg;
    logic [IW-1:0] iv_reg;
    logic [31:0] rc_reg, rl_reg;

    logic [2:0]  cmd_reg;
    logic [95:0] tgt_reg;
    logic [2:0]  steps_reg;
    logic        acc_reg;
    logic [14:0] delay_reg;
    logic [1:0]  ax_reg;
    logic        ramp_add_reg;

    // Serial divider: 2c / d, restoring, one bit per cycle.
    logic [DW-1:0] dq_reg;
    logic [33:0]   drem_reg;
    logic [33:0]   dden_reg;
    logic [CW-1:0] dcnt_reg;

    logic [95:0] rd_data;
    logic        q_we;

    mabsr_ram #(.WIDTH(96), .DEPTH(QUEUE_DEPTH)) u_queue (
        .clk  (clk),
        .we   (q_we),
        .waddr(tail_reg),
        .wdata(tgt_reg),
        .raddr(head_reg),
        .rdata(rd_data)
    );

    logic in_acc, out_acc;
    assign s_axis_tready = (state_reg == ST_IDLE) && !m_axis_tvalid;
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;
    assign cfg_ready = 1'b1;
    assign q_we = (state_reg == ST_RD) && (cmd_reg == CMD_ENQUEUE)
                  && (fill_reg < FW'(QUEUE_DEPTH));

    // Working signals for the alarm step of the current axis and the move distances used at start.
    logic        ax_live;
    logic [32:0] ax_e;
    logic        ax_step;
    logic [31:0] lead_done;
    logic        all_done;
    logic [31:0] ad [3];
    logic        aneg [3];
    always_comb
    begin
        ax_live = en_reg[ax_reg] && dist_reg[ax_reg] != '0
                  && done_reg[ax_reg] < dist_reg[ax_reg];
        ax_e = {1'b0, err_reg[ax_reg]} + {1'b0, dist_reg[ax_reg]};
        ax_step = ax_live && (ax_e >= {1'b0, longest_reg});
        lead_done = done_reg[lead_reg];
        all_done = 1'b1;
        for (int i = 0; i < AXES; i++)
        begin
            if (en_reg[i] && dist_reg[i] != '0 && done_reg[i] < dist_reg[i])
                all_done = 1'b0;
        end
        for (int i = 0; i < 3; i++)
        begin
            logic [32:0] d;
            d = {tgt_reg[32*i+31], tgt_reg[32*i +: 32]} - {pos_reg[i][31], pos_reg[i]};
            aneg[i] = d[32];
            ad[i] = d[32] ? 32'(-d) : d[31:0];
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (in_acc) state_next = ST_RD;
            ST_RD:
            begin
                if (cmd_reg == CMD_RUN && !active_reg && fill_reg != '0)
                    state_next = ST_RD_WAIT;
                else if (cmd_reg == CMD_ALARM && active_reg && !all_done)
                    state_next = ST_ALARM;
                else
                    state_next = ST_OUT;
            end
            ST_RD_WAIT:   state_next = ST_START;
            ST_START:     state_next = ST_START2;
            ST_START2:    state_next = ST_OUT;
            ST_ALARM:     state_next = (ax_reg == 2'(AXES - 1)) ? ST_DIV_SETUP : ST_ALARM;
            ST_DIV_SETUP: state_next = ST_DIV;
            ST_DIV:       state_next = (dcnt_reg == '0) ? ST_RAMP : ST_DIV;
            ST_RAMP:      state_next = ST_OUT;
            ST_OUT:       state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    logic [33:0] rc_p1_x4;
    logic [IW:0] iv_sum;
    logic [34:0] dtrial;
    always_comb
    begin
        rc_p1_x4 = {rc_reg + 32'd1, 2'b00};
        iv_sum = {1'b0, iv_reg} + {1'b0, dq_reg[IW-1:0]};
        dtrial = {drem_reg, dq_reg[DW-1]} - {1'b0, dden_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            init_iv_reg <= INIT_INTERVAL_RST;
            min_iv_reg <= MIN_INTERVAL_RST;
            en_reg <= AXIS_ENABLE_RST;
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[i] <= '0;
                dist_reg[i] <= '0;
                err_reg[i] <= '0;
                done_reg[i] <= '0;
            end
            neg_reg <= '0;
            longest_reg <= '0;
            lead_reg <= '0;
            active_reg <= 1'b0;
            iv_reg <= '0;
            rc_reg <= '0;
            rl_reg <= '0;
            m_axis_tvalid <= 1'b0;
            cmd_reg <= '0;
            dcnt_reg <= '0;
            ax_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_INIT_INTERVAL: init_iv_reg <= cfg_data;
                    REG_MIN_INTERVAL:  min_iv_reg <= cfg_data;
                    REG_AXIS_ENABLE:   en_reg <= cfg_data[2:0];
                    default:           ;
                endcase
            end
            if (out_acc)
                m_axis_tvalid <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        cmd_reg <= s_axis_tuser;
                        tgt_reg <= s_axis_tdata;
                        steps_reg <= '0;
                        acc_reg <= 1'b0;
                        delay_reg <= '0;
                        ax_reg <= '0;
                    end
                end
                ST_RD:
                begin
                    case (cmd_reg)
                        CMD_ENQUEUE:
                        begin
                            if (fill_reg < FW'(QUEUE_DEPTH))
                            begin
                                tail_reg <= (tail_reg == QW'(QUEUE_DEPTH - 1)) ? '0
                                            : tail_reg + 1'b1;
                                fill_reg <= fill_reg + 1'b1;
                                acc_reg <= 1'b1;
                            end
                        end
                        CMD_ALARM:
                        begin
                            if (active_reg && all_done)
                            begin
                                active_reg <= 1'b0;
                                ax_reg <= '0;
                            end
                        end
                        CMD_STOP:
                        begin
                            active_reg <= 1'b0;
                            head_reg <= '0;
                            tail_reg <= '0;
                            fill_reg <= '0;
                        end
                        CMD_ZERO:
                        begin
                            if (!active_reg && fill_reg == '0)
                            begin
                                for (int i = 0; i < AXES; i++)
                                    if (en_reg[i]) pos_reg[i] <= '0;
                                acc_reg <= 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                ST_RD_WAIT: ;
                ST_START:
                begin
                    tgt_reg <= rd_data;
                    head_reg <= (head_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
                    fill_reg <= fill_reg - 1'b1;
                end
                ST_START2:
                begin
                    logic [31:0] lg;
                    logic [1:0]  la;
                    lg = '0;
                    la = '0;
                    for (int i = 0; i < AXES; i++)
                    begin
                        done_reg[i] <= '0;
                        if (en_reg[i])
                        begin
                            neg_reg[i] <= aneg[i];
                            dist_reg[i] <= ad[i];
                            if (ad[i] > lg)
                            begin
                                lg = ad[i];
                                la = 2'(i);
                            end
                        end
                        else
                        begin
                            neg_reg[i] <= 1'b0;
                            dist_reg[i] <= '0;
                            err_reg[i] <= '0;
                        end
                    end
                    longest_reg <= lg;
                    lead_reg <= la;
                    if (lg != '0)
                    begin
                        for (int i = 0; i < AXES; i++)
                            err_reg[i] <= (en_reg[i] && ad[i] != '0) ? (lg >> 1) : '0;
                        active_reg <= 1'b1;
                        iv_reg <= {init_iv_reg, {FRAC_BITS{1'b0}}};
                        rc_reg <= '0;
                        rl_reg <= '0;
                        delay_reg <= init_iv_reg[15:1];
                    end
                end
                ST_ALARM:
                begin
                    if (ax_live)
                    begin
                        err_reg[ax_reg] <= ax_step ? 32'(ax_e - {1'b0, longest_reg})
                                                   : ax_e[31:0];
                        if (ax_step)
                        begin
                            pos_reg[ax_reg] <= neg_reg[ax_reg] ? pos_reg[ax_reg] - 32'd1
                                                               : pos_reg[ax_reg] + 32'd1;
                            done_reg[ax_reg] <= done_reg[ax_reg] + 32'd1;
                            steps_reg[ax_reg] <= 1'b1;
                        end
                    end
                    ax_reg <= ax_reg + 1'b1;
                end
                ST_DIV_SETUP:
                begin
                    // Dividend 2c, divisor 4n+1 (accel) or 4n-1 (decel, n after dec); no division otherwise.
                    dq_reg <= {iv_reg, 1'b0};
                    drem_reg <= '0;
                    dcnt_reg <= CW'(DW);
                    ramp_add_reg <= 1'b0;
                    if (rl_reg == '0)
                    begin
                        dden_reg <= rc_p1_x4 + 34'd1;
                        rc_reg <= rc_reg + 32'd1;
                    end
                    else if ({1'b0, lead_done} + {1'b0, rl_reg} >= {1'b0, longest_reg}
                             && rc_reg > 32'd1)
                    begin
                        dden_reg <= {rc_reg - 32'd1, 2'b00} - 34'd1;
                        rc_reg <= rc_reg - 32'd1;
                        ramp_add_reg <= 1'b1;
                    end
                    else
                    begin
                        if ({1'b0, lead_done} + {1'b0, rl_reg} >= {1'b0, longest_reg}
                            && rc_reg == 32'd1)
                            rc_reg <= '0;
                        dcnt_reg <= '0;
                        dden_reg <= '0;
                        dq_reg <= '0;
                    end
                end
                ST_DIV:
                begin
                    if (dcnt_reg != '0)
                    begin
                        if (!dtrial[34])
                        begin
                            drem_reg <= dtrial[33:0];
                            dq_reg <= {dq_reg[DW-2:0], 1'b1};
                        end
                        else
                        begin
                            drem_reg <= {drem_reg[32:0], dq_reg[DW-1]};
                            dq_reg <= {dq_reg[DW-2:0], 1'b0};
                        end
                        dcnt_reg <= dcnt_reg - 1'b1;
                    end
                end
                ST_RAMP:
                begin
                    logic [IW:0] c;
                    if (rl_reg == '0)
                    begin
                        c = {1'b0, iv_reg} - {1'b0, dq_reg[IW-1:0]};
                        if (c <= {1'b0, min_iv_reg, {FRAC_BITS{1'b0}}})
                            c = {1'b0, min_iv_reg, {FRAC_BITS{1'b0}}};
                        // The ramp ends at the speed limit or at the move midpoint.
                        if (c == {1'b0, min_iv_reg, {FRAC_BITS{1'b0}}}
                            || lead_done >= (longest_reg >> 1))
                            rl_reg <= lead_done;
                    end
                    else if (ramp_add_reg)
                        c = (dq_reg[DW-1] || iv_sum > {1'b0, IV_MAX}) ? {1'b0, IV_MAX}
                                                                       : iv_sum;
                    else
                        c = {1'b0, iv_reg};
                    iv_reg <= c[IW-1:0];
                    delay_reg <= c[FRAC_BITS+15:FRAC_BITS+1];
                end
                ST_OUT:
                begin
                    m_axis_tvalid <= 1'b1;
                    m_axis_tdata <= {3'b000,
                                     (AXES > 2) ? pos_reg[2] : 32'd0,
                                     (AXES > 1) ? pos_reg[1] : 32'd0,
                                     pos_reg[0],
                                     5'(fill_reg),
                                     acc_reg,
                                     !active_reg && fill_reg == '0,
                                     active_reg,
                                     delay_reg,
                                     neg_reg,
                                     steps_reg};
                end
                default: ;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(QUEUE_DEPTH))
        else $error("queue fill above depth");
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> state_reg != ST_DIV)
        else $error("divider busy while result pending");
    assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> state_reg == ST_RD)
        else $error("accepted request not processed");
endmodule
`default_nettype wire

// ===== verif/multi_axis_bresenham_stepper_ramp_unit_test.sv =====
// Self-checking testbench for the three-axis step interpolator with speed ramp.
`timescale 1ns / 100ps
`default_nettype none
module multi_axis_bresenham_stepper_ramp_unit_test;
    import mabsr_pkg::*;

    typedef struct packed {
        logic [2:0]  step_mask;
        logic [2:0]  dir_mask;
        logic [14:0] next_delay_us;
        logic        moving;
        logic        idle;
        logic        accepted;
        logic [4:0]  queued;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
    } status_t;

    // Predictor of the interpolator plus the queue of expected status words.
    class motion_scoreboard;
        logic [31:0] tgt [16][3];
        int unsigned head, tail, fill;
        logic [31:0] pos [3];
        logic [31:0] span [3];
        logic [31:0] err [3];
        logic [31:0] done [3];
        bit          neg [3];
        logic [31:0] longest;
        int unsigned lead;
        bit          active;
        longint unsigned ivl;
        logic [31:0] ramp_n, ramp_len;
        logic [15:0] init_ivl, min_ivl;
        logic [2:0]  enables;
        status_t     pending [$];
        int          mismatches;

        function new();
            head = 0; tail = 0; fill = 0; active = 0; ivl = 0; ramp_n = 0; ramp_len = 0;
            longest = 0; lead = 0; mismatches = 0;
            init_ivl = INIT_INTERVAL_RST; min_ivl = MIN_INTERVAL_RST; enables = AXIS_ENABLE_RST;
            for (int i = 0; i < 3; i++)
            begin
                pos[i] = 0; span[i] = 0; err[i] = 0; done[i] = 0; neg[i] = 0;
            end
        endfunction

        function void write_reg(reg_idx_t idx, logic [15:0] v);
            case (idx)
                REG_INIT_INTERVAL: init_ivl = v;
                REG_MIN_INTERVAL:  min_ivl = v;
                REG_AXIS_ENABLE:   enables = v[2:0];
                default: ;
            endcase
        endfunction

        function logic [14:0] half_ivl();
            return 15'((ivl >> 8) >> 1);
        endfunction

        function logic [14:0] start_move();
            longint signed d;
            if (active || fill == 0)
                return 0;
            longest = 0; lead = 0;
            for (int i = 0; i < 3; i++)
            begin
                done[i] = 0;
                if (enables[i])
                begin
                    d = longint'($signed(tgt[head][i])) - longint'($signed(pos[i]));
                    neg[i] = d < 0;
                    span[i] = 32'(d < 0 ? -d : d);
                    if (span[i] > longest)
                    begin
                        longest = span[i];
                        lead = i;
                    end
                end
                else
                begin
                    neg[i] = 0; span[i] = 0; err[i] = 0;
                end
            end
            head = (head + 1) % 16;
            fill--;
            if (longest == 0)
                return 0;
            for (int i = 0; i < 3; i++)
                err[i] = span[i] > 0 ? longest / 2 : 0;
            active = 1;
            ivl = longint'(init_ivl) << 8;
            ramp_n = 0; ramp_len = 0;
            return half_ivl();
        endfunction

        function logic [14:0] alarm(output logic [2:0] steps);
            bit finished;
            longint unsigned c, e, n, lead_done;
            steps = 0;
            finished = 1;
            c = ivl;
            if (!active)
                return 0;
            for (int i = 0; i < 3; i++)
                if (enables[i] && span[i] > 0 && done[i] < span[i])
                    finished = 0;
            if (finished)
            begin
                active = 0;
                return 0;
            end
            for (int i = 0; i < 3; i++)
                if (enables[i] && span[i] > 0 && done[i] < span[i])
                begin
                    e = longint'(err[i]) + span[i];
                    if (e >= longest)
                    begin
                        e -= longest;
                        pos[i] = neg[i] ? pos[i] - 1 : pos[i] + 1;
                        done[i]++;
                        steps[i] = 1;
                    end
                    err[i] = 32'(e);
                end
            lead_done = done[lead];
            if (ramp_len == 0)
            begin
                ramp_n++;
                n = ramp_n;
                c -= (2 * c) / (4 * n + 1);
                if (c <= (longint'(min_ivl) << 8))
                begin
                    c = longint'(min_ivl) << 8;
                    ramp_len = 32'(lead_done);
                end
                if (lead_done >= longest / 2)
                    ramp_len = 32'(lead_done);
            end
            else if (lead_done + ramp_len >= longest)
            begin
                if (ramp_n > 0)
                begin
                    ramp_n--;
                    if (ramp_n > 0)
                    begin
                        n = ramp_n;
                        c += (2 * c) / (4 * n - 1);
                    end
                end
            end
            if (c > (longint'(65535) << 8))
                c = longint'(65535) << 8;
            ivl = c;
            return half_ivl();
        endfunction

        function void note_request(cmd_t cmd, logic [95:0] data);
            status_t s;
            s = '0;
            case (cmd)
                CMD_ENQUEUE:
                    if (fill < 16)
                    begin
                        for (int i = 0; i < 3; i++)
                            tgt[tail][i] = data[32*i +: 32];
                        tail = (tail + 1) % 16;
                        fill++;
                        s.accepted = 1;
                    end
                CMD_RUN: s.next_delay_us = start_move();
                CMD_ALARM: s.next_delay_us = alarm(s.step_mask);
                CMD_STOP:
                begin
                    active = 0; head = 0; tail = 0; fill = 0;
                end
                CMD_ZERO:
                    if (!active && fill == 0)
                    begin
                        for (int i = 0; i < 3; i++)
                            if (enables[i])
                                pos[i] = 0;
                        s.accepted = 1;
                    end
                default: ;
            endcase
            for (int i = 0; i < 3; i++)
                s.dir_mask[i] = neg[i];
            s.moving = active;
            s.idle = !active && fill == 0;
            s.queued = 5'(fill);
            s.pos_x = pos[0]; s.pos_y = pos[1]; s.pos_z = pos[2];
            pending.push_back(s);
        endfunction

        function void check_status(logic [127:0] word);
            status_t got, want;
            got = status_t'({word[2:0], word[5:3], word[20:6], word[21], word[22],
                             word[23], word[28:24], word[60:29], word[92:61],
                             word[124:93]});
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result %h", word);
                return;
            end
            want = pending.pop_front();
            if (got !== want || word[127:125] !== 3'b0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: status mismatch exp %p got %p", want, got);
            end
        endfunction
    endclass

    logic         clk = 0;
    logic         rst_n = 0;
    logic         s_axis_tvalid = 0;
    wire          s_axis_tready;
    logic [95:0]  s_axis_tdata = '0;
    logic [2:0]   s_axis_tuser = '0;
    wire          m_axis_tvalid;
    logic         m_axis_tready = 0;
    wire  [127:0] m_axis_tdata;
    logic         cfg_valid = 0;
    wire          cfg_ready;
    logic [1:0]   cfg_index = '0;
    logic [15:0]  cfg_data = '0;

    int  send_gap_pct, recv_stall_pct;
    int  cycles;
    int  sent;
    motion_scoreboard sb = new();

    always #5 clk = ~clk;

    multi_axis_bresenham_stepper_ramp_unit dut (.*);

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_status(m_axis_tdata);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 3000000)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_request(cmd_t cmd, logic [95:0] data);
        while ($urandom_range(99) < send_gap_pct)
            @(posedge clk);
        s_axis_tvalid <= 1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= data;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_request(cmd, data);
        sent++;
        s_axis_tvalid <= 0;
        // The block stays busy after an accept.
        @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [15:0] v);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 0;
        sb.write_reg(idx, v);
    endtask

    function automatic logic [31:0] near_target(logic [31:0] p);
        return p + 32'($signed($urandom_range(80)) - 40);
    endfunction

    // Queue one to three short moves and run them to completion through alarms.
    task automatic move_burst();
        int k;
        k = $urandom_range(1, 3);
        for (int i = 0; i < k; i++)
            send_request(CMD_ENQUEUE, {near_target(sb.pos[2]), near_target(sb.pos[1]),
                                       near_target(sb.pos[0])});
        for (int i = 0; i < k; i++)
        begin
            send_request(CMD_RUN, '0);
            for (int j = 0; j < 90 && sb.active; j++)
                send_request(CMD_ALARM, '0);
            if ($urandom_range(3) == 0)
                send_request(CMD_ALARM, '0);
        end
    endtask

    task automatic noise_request();
        logic [95:0] d;
        d = {$urandom, $urandom, $urandom};
        case ($urandom_range(9))
            0: send_request(CMD_STOP, '0);
            1: send_request(CMD_ZERO, '0);
            2: send_request(CMD_ENQUEUE, d);
            3: send_request(CMD_RUN, '0);
            4: send_request(cmd_t'(3'($urandom_range(5, 7))), d);
            default: send_request(CMD_ALARM, '0);
        endcase
    endtask

    task automatic random_phase(int n_items);
        int start;
        start = sent;
        while (sent - start < n_items)
        begin
            if ($urandom_range(4) == 0)
                noise_request();
            else
                move_burst();
        end
        // A stop leaves the queue empty so positions can be re-zeroed.
        send_request(CMD_STOP, '0);
    endtask

    initial
    begin
        send_gap_pct = 30;
        recv_stall_pct = 77;
        cycles = 0;
        sent = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: extremes, queue full, zero refusal, empty run, alarm while idle.
        send_request(CMD_ALARM, '0);
        send_request(CMD_RUN, '0);
        send_request(CMD_ZERO, '0);
        send_request(CMD_ENQUEUE, {32'h7fffffff, 32'h80000000, 32'hffffffff});
        send_request(CMD_ZERO, '0);
        send_request(CMD_STOP, '0);
        for (int i = 0; i < 17; i++)
            send_request(CMD_ENQUEUE, {32'd0, 32'(-i), 32'(i)});
        send_request(CMD_RUN, '0);
        send_request(CMD_RUN, '0);
        send_request(CMD_ALARM, '0);
        send_request(CMD_STOP, '0);
        send_request(cmd_t'(3'd7), '1);
        send_request(CMD_ENQUEUE, '0);
        send_request(CMD_RUN, '0);

        write_reg(REG_AXIS_ENABLE, 16'd7);
        send_request(CMD_ENQUEUE, {32'h80000000, 32'h80000000, 32'h7fffffff});
        send_request(CMD_RUN, '0);
        for (int i = 0; i < 4; i++)
            send_request(CMD_ALARM, '0);
        send_request(CMD_STOP, '0);
        send_request(CMD_ZERO, '0);

        random_phase(120);
        write_reg(REG_INIT_INTERVAL, 16'd1);
        write_reg(REG_MIN_INTERVAL, 16'd65535);
        write_reg(REG_AXIS_ENABLE, 16'd5);
        send_gap_pct = 77;
        recv_stall_pct = 30;
        random_phase(120);
        write_reg(REG_INIT_INTERVAL, 16'd65535);
        write_reg(REG_MIN_INTERVAL, 16'd1);
        write_reg(REG_AXIS_ENABLE, 16'd0);
        random_phase(30);
        write_reg(REG_AXIS_ENABLE, 16'd6);
        write_reg(REG_INIT_INTERVAL, 16'($urandom_range(2, 9000)));
        write_reg(REG_MIN_INTERVAL, 16'($urandom_range(1, 2000)));
        send_gap_pct = 0;
        recv_stall_pct = 0;
        random_phase(120);

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (sb.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
rtl/core/mabsr_pkg.sv
rtl/core/mabsr_ram.sv
rtl/core/multi_axis_bresenham_stepper_ramp_unit.sv
verif/multi_axis_bresenham_stepper_ramp_unit_test.sv
